/* src/dim_pkg.sv */
package dim_pkg;

    // Table geometry.
    localparam int FD_SLOTS   = 64;
    localparam int FD_BITS    = 6;
    localparam int INDEX_BITS = 16;

    typedef logic [FD_BITS-1:0]    fd_t;
    typedef logic [INDEX_BITS-1:0] idx_t;

    // Command codes carried in the input tuser.
    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_PURGE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    // Result status codes carried in the output tuser.
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_MAP_USED   = 2'd1,
        STAT_NOT_MAPPED = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_LOOKUP,
        S_WALK,
        S_DRAIN,
        S_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic do_map;
        logic map_reject;
        logic do_clear;
        logic purge_miss;
        logic rd_slot;
        logic take_gone;
        logic walk_en;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic hit;
        logic walk_last;
        logic out_free;
    } dp_stat_t;

endpackage

/* src/descriptor_index_map.sv */
// Descriptor index map: a table from descriptor slot to dense request index.
// Commands arrive as transfers on the s_axis channel: tuser holds the command
// (map, purge, clear, or a no-op code), tdata the slot and the index. Each
// command yields exactly one result transfer on the m_axis channel: tdata is
// the index the purged slot held (zero otherwise), tuser the status.
// Map, clear and no-op commands, and a purge of an unused slot, pass from the
// execute state straight to the finish state, which loads the result register;
// the input is ready again in the cycle that the result valid rises.
// A purge of a mapped slot first reads the slot's index, then walks every
// slot once through the single read port of the index memory, one slot a
// cycle, decrementing every used index above the purged one, before its result
// is loaded.
// One command is worked on at a time; a new command is accepted the cycle after
// the previous result lands in the output register, even while it waits.
// A stalled receiver holds the result in the output register, and the next
// command then waits for that register to empty before its own result lands.
// Reset marks every slot unused at once; no clearing pass is needed, and the
// index held for an unused slot is never acted on.
module descriptor_index_map
    import dim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // fd[5:0], index[21:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // old_index[15:0]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    dim_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    dim_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .stat          (stat)
    );

    // Only one command is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while another is in work");

    // A result that is not ok never carries an index.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata == '0)
        else $error("failed command returned a nonzero index");

    // Only defined status codes are produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == STAT_OK || m_axis_tuser == STAT_MAP_USED
                           || m_axis_tuser == STAT_NOT_MAPPED))
        else $error("undefined status code");

    // The walk only runs after a purge hit a used slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_gone |-> $past(cmd.rd_slot))
        else $error("purge walk started without a slot lookup");

endmodule

/* src/dim_ctrl.sv */
module dim_ctrl
    import dim_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (stat.cmd == CMD_PURGE && stat.hit)
                begin
                    state_next = S_LOOKUP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.walk_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                cmd.load      = s_axis_tvalid;
            end
            S_EXEC:
            begin
                case (stat.cmd)
                    CMD_MAP:
                    begin
                        cmd.do_map     = !stat.hit;
                        cmd.map_reject = stat.hit;
                    end
                    CMD_PURGE:
                    begin
                        cmd.rd_slot    = stat.hit;
                        cmd.purge_miss = !stat.hit;
                    end
                    CMD_CLEAR:
                    begin
                        cmd.do_clear = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_LOOKUP:
            begin
                cmd.take_gone = 1'b1;
            end
            S_WALK:
            begin
                cmd.walk_en = 1'b1;
            end
            S_FINISH:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* src/dim_dp.sv */
module dim_dp
    import dim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  s_axis_tuser,
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat
);

    // Latched command.
    cmd_t    cmd_reg;
    fd_t     fd_reg;
    idx_t    index_reg;
    idx_t    old_reg;
    status_t status_reg;
    idx_t    gone_reg;

    // Table: used bits in flops, indices in a memory.
    logic [FD_SLOTS-1:0] used_reg;
    idx_t                mem [FD_SLOTS];
    idx_t                rd_data_reg;

    // Purge walk.
    fd_t  walk_reg;
    logic walk_vld_reg;
    fd_t  walk_addr_reg;

    // Output register.
    logic    m_valid_reg;
    idx_t    m_data_reg;
    status_t m_user_reg;

    fd_t  rd_addr;
    logic walk_hit;
    logic wr_en;
    fd_t  wr_addr;
    idx_t wr_data;

    // The walk decrements a used entry whose index lies above the purged one.
    assign walk_hit = walk_vld_reg && used_reg[walk_addr_reg] && (rd_data_reg > gone_reg);

    // Memory port selection.
    assign rd_addr = cmd.rd_slot ? fd_reg : walk_reg;
    assign wr_en   = cmd.do_map || walk_hit;
    assign wr_addr = cmd.do_map ? fd_reg : walk_addr_reg;
    assign wr_data = cmd.do_map ? index_reg : idx_t'(rd_data_reg - 1'b1);

    // Index memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Command fields and result values.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg    <= cmd_t'(s_axis_tuser);
            fd_reg     <= s_axis_tdata[FD_BITS-1:0];
            index_reg  <= s_axis_tdata[FD_BITS +: INDEX_BITS];
            old_reg    <= '0;
            status_reg <= STAT_OK;
        end
        if (cmd.map_reject)
        begin
            status_reg <= STAT_MAP_USED;
        end
        if (cmd.purge_miss)
        begin
            status_reg <= STAT_NOT_MAPPED;
        end
        if (cmd.take_gone)
        begin
            gone_reg <= rd_data_reg;
            old_reg  <= rd_data_reg;
        end
        if (cmd.out_load)
        begin
            m_data_reg <= old_reg;
            m_user_reg <= status_reg;
        end
    end

    // Used bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.do_clear)
        begin
            used_reg <= '0;
        end
        else if (cmd.do_map)
        begin
            used_reg[fd_reg] <= 1'b1;
        end
        else if (cmd.rd_slot)
        begin
            used_reg[fd_reg] <= 1'b0;
        end
    end

    // Walk counter and its delayed address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg      <= '0;
            walk_vld_reg  <= 1'b0;
            walk_addr_reg <= '0;
        end
        else
        begin
            walk_vld_reg  <= cmd.walk_en;
            walk_addr_reg <= walk_reg;
            if (cmd.take_gone)
            begin
                walk_reg <= '0;
            end
            else if (cmd.walk_en)
            begin
                walk_reg <= walk_reg + 1'b1;
            end
        end
    end

    // Output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign stat.cmd       = cmd_reg;
    assign stat.hit       = used_reg[fd_reg];
    assign stat.walk_last = (walk_reg == fd_t'(FD_SLOTS - 1));
    assign stat.out_free  = !m_valid_reg || m_axis_tready;

endmodule

/* tb/dim_checker.sv */
`timescale 1ns / 100ps

// Watches both stream channels of the descriptor index map, keeps its own copy
// of the slot table, and compares every result transfer with the oldest
// predicted result.
module dim_checker
    import dim_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // fd[5:0], index[21:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // old_index[15:0]
    input  logic [1:0]  m_axis_tuser,   // status[1:0]
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        idx_t    old_index;
        status_t status;
    } map_result_t;

    // Shadow copy of the slot table.
    bit   slot_live [FD_SLOTS];
    idx_t slot_idx  [FD_SLOTS];

    map_result_t awaited_results[$];

    // Applies one command to the shadow table and returns the result it yields.
    function automatic map_result_t apply_command(cmd_t c, fd_t f, idx_t i);
        map_result_t r;
        idx_t        gone;
        r.old_index = '0;
        r.status    = STAT_OK;
        case (c)
            CMD_MAP:
            begin
                if (slot_live[f])
                begin
                    r.status = STAT_MAP_USED;
                end
                else
                begin
                    slot_idx[f]  = i;
                    slot_live[f] = 1'b1;
                end
            end
            CMD_PURGE:
            begin
                if (!slot_live[f])
                begin
                    r.status = STAT_NOT_MAPPED;
                end
                else
                begin
                    gone         = slot_idx[f];
                    slot_live[f] = 1'b0;
                    // Close the hole so the remaining indices stay dense.
                    for (int k = 0; k < FD_SLOTS; k++)
                    begin
                        if (slot_live[k] && slot_idx[k] > gone)
                        begin
                            slot_idx[k] = slot_idx[k] - 1'b1;
                        end
                    end
                    r.old_index = gone;
                end
            end
            CMD_CLEAR:
            begin
                for (int k = 0; k < FD_SLOTS; k++)
                begin
                    slot_live[k] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Compare results first, then predict the command taken at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        map_result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < FD_SLOTS; k++)
            begin
                slot_live[k] = 1'b0;
                slot_idx[k]  = '0;
            end
            awaited_results.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("unexpected result transfer: old_index %0h, status %0d",
                           m_axis_tdata, m_axis_tuser);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (m_axis_tdata !== want.old_index)
                    begin
                        $error("old_index mismatch: expected %0h, actual %0h",
                               want.old_index, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, m_axis_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_results.push_back(apply_command(cmd_t'(s_axis_tuser),
                                                        s_axis_tdata[5:0],
                                                        s_axis_tdata[21:6]));
            end
            pending = awaited_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Drives commands into the descriptor index map, stalls the result channel at
// random, and reports the verdict from the checker's failure count.
module tb_top
    import dim_pkg::*;
();

    localparam int  RANDOM_ITEMS = 1830;
    localparam int  CYCLE_LIMIT  = 900000;
    localparam int  TAIL_CYCLES  = 80;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // fd[5:0], index[21:6], zero pad
    logic [1:0]  s_axis_tuser;   // cmd[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // old_index[15:0]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    int fail_count;
    int pending;
    int cycle_count;
    bit calm;

    // Slots the stimulus believes are mapped; used only to steer commands.
    bit slot_taken [FD_SLOTS];

    descriptor_index_map u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dim_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Result channel back-pressure, changed at the falling edge.
    always @(negedge clk)
    begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 30);
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("descriptor_index_map test failed");
            $finish;
        end
    end

    // Sends one command transfer, with an occasional idle gap in front of it.
    task automatic issue(cmd_t c, fd_t f, idx_t i);
        int gap;
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 90)
                                              : $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= {2'b00, i, f};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        case (c)
            CMD_MAP:   slot_taken[f] = 1'b1;
            CMD_PURGE: slot_taken[f] = 1'b0;
            CMD_CLEAR:
            begin
                for (int k = 0; k < FD_SLOTS; k++)
                begin
                    slot_taken[k] = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Finds a slot whose mapped state matches want_taken, scanning from a
    // random start. Returns 0 when there is none.
    function automatic bit pick_slot(bit want_taken, output fd_t f);
        int start;
        start = $urandom_range(0, FD_SLOTS - 1);
        for (int k = 0; k < FD_SLOTS; k++)
        begin
            f = fd_t'((start + k) % FD_SLOTS);
            if (slot_taken[f] == want_taken)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Counts mapped slots; a dense map index equals this count.
    function automatic idx_t live_count();
        idx_t n;
        n = '0;
        for (int k = 0; k < FD_SLOTS; k++)
        begin
            n += idx_t'(slot_taken[k]);
        end
        return n;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        fd_t  f;
        idx_t i;
        int   r;
        bit   found;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_NONE;
        calm          = 1'b0;
        for (int k = 0; k < FD_SLOTS; k++)
        begin
            slot_taken[k] = 1'b0;
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: field extremes, rejections, misses, dense compaction.
        issue(CMD_CLEAR, 6'd0, 16'h0000);
        issue(CMD_MAP,   6'd0, 16'h0000);
        issue(CMD_MAP,   6'd63, 16'hFFFF);
        issue(CMD_MAP,   6'd0, 16'h1234);
        issue(CMD_PURGE, 6'd5, 16'hFFFF);
        issue(CMD_PURGE, 6'd63, 16'h0000);
        issue(CMD_MAP,   6'd63, 16'h0001);
        issue(CMD_MAP,   6'd10, 16'h0002);
        issue(CMD_MAP,   6'd20, 16'h0003);
        issue(CMD_MAP,   6'd30, 16'hAAAA);
        issue(CMD_MAP,   6'd40, 16'h5555);
        issue(CMD_PURGE, 6'd10, 16'h0000);
        issue(CMD_PURGE, 6'd0,  16'h0000);
        issue(CMD_NONE,  6'd21, 16'hFFFF);
        issue(CMD_PURGE, 6'd30, 16'h0000);
        issue(CMD_CLEAR, 6'd63, 16'hFFFF);
        issue(CMD_PURGE, 6'd20, 16'h0000);
        issue(CMD_MAP,   6'd20, 16'h0007);
        issue(CMD_PURGE, 6'd20, 16'h0000);

        // Random part: mostly well-formed map and purge traffic, some noise.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 700 && n < 1000);
            r    = $urandom_range(0, 99);
            i    = ($urandom_range(0, 99) < 70) ? live_count()
                                                 : idx_t'($urandom_range(0, 65535));
            if (r < 45)
            begin
                found = pick_slot(1'b0, f);
                issue(found ? CMD_MAP : CMD_PURGE, f, i);
            end
            else if (r < 85)
            begin
                found = pick_slot(1'b1, f);
                issue(found ? CMD_PURGE : CMD_MAP, f, i);
            end
            else if (r < 91)
            begin
                found = pick_slot(1'b1, f);
                issue(CMD_MAP, f, idx_t'($urandom_range(0, 65535)));
            end
            else if (r < 96)
            begin
                found = pick_slot(1'b0, f);
                issue(CMD_PURGE, f, idx_t'($urandom_range(0, 65535)));
            end
            else if (r < 98)
            begin
                issue(CMD_CLEAR, fd_t'($urandom_range(0, 63)),
                      idx_t'($urandom_range(0, 65535)));
            end
            else
            begin
                issue(CMD_NONE, fd_t'($urandom_range(0, 63)),
                      idx_t'($urandom_range(0, 65535)));
            end
        end
        calm          = 1'b0;
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then watch for stray transfers.
        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("descriptor_index_map test passed");
        end
        else
        begin
            $display("descriptor_index_map test failed");
        end
        $finish;
    end

endmodule
